// ----- src/mfb_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the monochrome framebuffer core
// no dependencies

package mfb_pkg;

  localparam int MFB_COLUMNS = 128;
  localparam int MFB_PAGES   = 8;

  localparam logic [2:0] OP_POINT   = 3'd0;
  localparam logic [2:0] OP_LINE    = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_WRBYTE  = 3'd3;
  localparam logic [2:0] OP_REFRESH = 3'd4;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic adj;
    logic rd_pix;
    logic wr_pix;
    logic adv;
    logic wr_byte;
    logic emit;
  } mfb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       bad;
    logic       need_adj;
    logic       last;
    logic       clr_last;
  } mfb_sts_t;

endpackage

// ----- src/mfb_ctrl.sv -----
`timescale 1ns / 1ps
// sequencing state machine for the framebuffer core
// depends on mfb_pkg

module mfb_ctrl import mfb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mfb_sts_t sts,
  output mfb_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_DEC  = 9'b000000100,
    S_ADJ  = 9'b000001000,
    S_WR   = 9'b000010000,
    S_CLR  = 9'b000100000,
    S_WRB  = 9'b001000000,
    S_REF  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_POINT, OP_LINE: state_nxt = sts.bad ? S_DONE : S_ADJ;
          OP_CLEAR:          state_nxt = S_CLR;
          OP_WRBYTE:         state_nxt = sts.bad ? S_DONE : S_WRB;
          OP_REFRESH:        state_nxt = S_REF;
          default:           state_nxt = S_DONE;
        endcase
      end
      S_ADJ: begin
        if (sts.need_adj) begin
          cmd.adj = 1'b1;
        end else begin
          cmd.rd_pix = 1'b1;
          state_nxt  = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_pix = 1'b1;
        if (sts.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_ADJ;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_WRB: begin
        cmd.wr_byte = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REF, S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_DEC))
    else $error("accepted request did not reach decode");

  a_read_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pix |-> $past(cmd.rd_pix))
    else $error("pixel write without prior read");

  a_adj_done_goes_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADJ && !sts.need_adj) |=> (state_r == S_WR))
    else $error("settled line step did not move to write");

endmodule

// ----- src/mfb_dp.sv -----
`timescale 1ns / 1ps
// framebuffer memory, line stepper and refresh counters
// depends on mfb_pkg

module mfb_dp import mfb_pkg::*; #(
  parameter int COLUMNS = MFB_COLUMNS,
  parameter int PAGES   = MFB_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mfb_cmd_t   cmd,
  output mfb_sts_t   sts,
  input  logic [2:0] in_op,
  input  logic [7:0] in_xa,
  input  logic [7:0] in_ya,
  input  logic [7:0] in_xb,
  input  logic [7:0] in_yb,
  input  logic       in_pixel_on,
  input  logic [6:0] in_column,
  input  logic [2:0] in_page,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  output logic       out_status,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_frame_end
);

  localparam int ROWS  = PAGES * 8;
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = 1 << AW;
  localparam int QW    = $clog2(COLUMNS + 3);

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr, pix_addr, ref_addr;
  logic [7:0]  wr_data;

  logic [2:0]  op_r;
  logic        bad_r, on_r, vert_r, sx_r, sy_r;
  logic [7:0]  x_r, y_r, xb_r, yb_r;
  logic [11:0] tax_r;
  logic signed [11:0] dy2_r, r_r;
  logic [CW-1:0] col_r;
  logic [PW-1:0] pg_r;
  logic [7:0]  bval_r;
  logic [AW-1:0] clr_cnt_r;
  logic [PW-1:0] ref_pg_r;
  logic [QW-1:0] ref_pos_r;

  logic        pt_bad, ln_bad, wb_bad, ld_bad;
  logic [7:0]  ax;
  logic [7:0]  mask;
  logic        ref_cmd;
  logic [7:0]  ref_byte;
  logic        ref_wrap, frame_wrap;

  // range checks
  assign pt_bad = ({1'b0, in_xa} >= 9'(COLUMNS)) || ({1'b0, in_ya} >= 9'(ROWS));
  assign ln_bad = pt_bad || ({1'b0, in_xb} >= 9'(COLUMNS)) || ({1'b0, in_yb} >= 9'(ROWS));
  assign wb_bad = ({2'b0, in_column} >= 9'(COLUMNS)) || ({6'b0, in_page} >= 9'(PAGES));
  assign ax     = (in_xb >= in_xa) ? (in_xb - in_xa) : (in_xa - in_xb);

  always_comb begin
    case (in_op)
      OP_POINT:  ld_bad = pt_bad;
      OP_LINE:   ld_bad = ln_bad;
      OP_WRBYTE: ld_bad = wb_bad;
      default:   ld_bad = 1'b0;
    endcase
  end

  // request capture and line stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      bad_r  <= ld_bad;
      on_r   <= (in_op == OP_POINT) ? in_pixel_on : 1'b1;
      vert_r <= (in_op == OP_POINT) || (in_xa == in_xb);
      x_r    <= in_xa;
      y_r    <= in_ya;
      xb_r   <= (in_op == OP_POINT) ? in_xa : in_xb;
      yb_r   <= (in_op == OP_POINT) ? in_ya : in_yb;
      sx_r   <= (in_xb > in_xa);
      sy_r   <= (in_yb > in_ya);
      tax_r  <= {3'b0, ax, 1'b0};
      dy2_r  <= 12'(signed'({2'b0, in_yb, 1'b0}) - signed'({2'b0, in_ya, 1'b0}));
      r_r    <= signed'({4'b0, ax});
      col_r  <= CW'(in_column);
      pg_r   <= PW'(in_page);
      bval_r <= in_byte_value;
    end else if (cmd.adj) begin
      if (r_r < 0) begin
        y_r <= y_r - 8'd1;
        r_r <= r_r + signed'(tax_r);
      end else begin
        y_r <= y_r + 8'd1;
        r_r <= r_r - signed'(tax_r);
      end
    end else if (cmd.adv) begin
      if (vert_r) begin
        y_r <= sy_r ? (y_r + 8'd1) : (y_r - 8'd1);
      end else begin
        x_r <= sx_r ? (x_r + 8'd1) : (x_r - 8'd1);
        r_r <= r_r + dy2_r;
      end
    end
  end

  assign sts.op       = op_r;
  assign sts.bad      = bad_r;
  assign sts.need_adj = !vert_r && ((r_r < 0) || (r_r >= signed'(tax_r)));
  assign sts.last     = vert_r ? (y_r == yb_r) : (x_r == xb_r);
  assign sts.clr_last = (clr_cnt_r == {AW{1'b1}});

  // memory ports
  assign pix_addr = {x_r[CW-1:0], PW'(y_r[7:3])};
  assign ref_addr = {CW'(ref_pos_r - QW'(3)), ref_pg_r};
  assign rd_addr  = cmd.rd_pix ? pix_addr : ref_addr;
  assign mask     = 8'd1 << y_r[2:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pix_addr;
    wr_data = on_r ? (rdata_r | mask) : (rdata_r & ~mask);
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = 8'd0;
    end else if (cmd.wr_byte) begin
      wr_en   = 1'b1;
      wr_addr = {col_r, pg_r};
      wr_data = bval_r;
    end else if (cmd.wr_pix) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // refresh stream position
  assign ref_cmd    = (ref_pos_r < QW'(3));
  assign ref_wrap   = (ref_pos_r == QW'(COLUMNS + 2));
  assign frame_wrap = ref_wrap && (ref_pg_r == PW'(PAGES - 1));

  always_comb begin
    case (ref_pos_r)
      QW'(0):  ref_byte = CMD_PAGE_BASE + 8'(ref_pg_r);
      QW'(1):  ref_byte = CMD_COL_LOW;
      QW'(2):  ref_byte = CMD_COL_HIGH;
      default: ref_byte = rdata_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_pg_r  <= '0;
      ref_pos_r <= '0;
    end else if (cmd.emit && op_r == OP_REFRESH) begin
      if (ref_wrap) begin
        ref_pos_r <= '0;
        ref_pg_r  <= frame_wrap ? '0 : (ref_pg_r + PW'(1));
      end else begin
        ref_pos_r <= ref_pos_r + QW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status    <= bad_r;
      out_byte      <= (op_r == OP_REFRESH) ? ref_byte : 8'd0;
      out_is_data   <= (op_r == OP_REFRESH) && !ref_cmd;
      out_frame_end <= (op_r == OP_REFRESH) && frame_wrap;
    end
  end

endmodule

// ----- src/mono_framebuffer_line_refresh_core.sv -----
`timescale 1ns / 1ps
// top level of the monochrome framebuffer with line draw and refresh stream
// depends on mfb_pkg, mfb_ctrl, mfb_dp
//
//   channel   | handshake               | payload
//   ----------+-------------------------+----------------------------------------
//   request   | start in, busy out      | in_op, in_xa/ya/xb/yb, in_pixel_on,
//             |                         | in_column, in_page, in_byte_value
//   result    | out_valid strobe out    | out_status, out_byte, out_is_data,
//             |                         | out_frame_end
//
// a request is taken on a clock edge with start high and busy low
// result strobe comes in the cycle after the work ends, exactly one per request
// busy stays high from the accepting edge through these states in order:
// point and line: decode, then per pixel any row steps of the error accumulator,
//   a read of the pixel byte and its write back, then done
// clear: decode, zero 2^(clog2(COLUMNS)+clog2(PAGES)) bytes (1024 by default),
//   one byte a cycle, then done; write byte: decode, write, done
// refresh: decode, emit; rejected or unused ops: decode, done
// after reset a clearing pass over all 1024 bytes runs with busy high;
//   the result side has no backpressure

module mono_framebuffer_line_refresh_core import mfb_pkg::*; #(
  parameter int COLUMNS = MFB_COLUMNS,
  parameter int PAGES   = MFB_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  logic [7:0] in_xa,
  input  logic [7:0] in_ya,
  input  logic [7:0] in_xb,
  input  logic [7:0] in_yb,
  input  logic       in_pixel_on,
  input  logic [6:0] in_column,
  input  logic [2:0] in_page,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  output logic       out_status,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_frame_end
);

  mfb_cmd_t cmd;
  mfb_sts_t sts;

  // sequencing
  mfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // storage, stepping and refresh
  mfb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_xa         (in_xa),
    .in_ya         (in_ya),
    .in_xb         (in_xb),
    .in_yb         (in_yb),
    .in_pixel_on   (in_pixel_on),
    .in_column     (in_column),
    .in_page       (in_page),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_is_data   (out_is_data),
    .out_frame_end (out_frame_end)
  );

endmodule
